/* src/cpf_pkg.sv */
// ----------------------------------------------------------------------------
// cpf_pkg
// shared types, constants and the crc-8 step function of the packet framer
// ----------------------------------------------------------------------------
package cpf_pkg;

    // payload bytes per frame, clamped to the range the position counter covers
    localparam int PAYLOAD_BYTES = 300;
    localparam int FRAME_LEN     = (PAYLOAD_BYTES < 2) ? 2 :
                                   ((PAYLOAD_BYTES > 511) ? 511 : PAYLOAD_BYTES);
    localparam int POS_W         = 9;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // sync header and crc polynomial
    localparam logic [7:0] SYNC0    = 8'hAA;
    localparam logic [7:0] SYNC1    = 8'h55;
    localparam logic [7:0] SYNC2    = 8'hA5;
    localparam logic [7:0] SYNC3    = 8'h5A;
    localparam logic [7:0] CRC_POLY = 8'h07;

    // emit step codes of the back sequencer
    localparam logic [2:0] STEP_HDR0   = 3'd0;
    localparam logic [2:0] STEP_HDR1   = 3'd1;
    localparam logic [2:0] STEP_HDR2   = 3'd2;
    localparam logic [2:0] STEP_HDR3   = 3'd3;
    localparam logic [2:0] STEP_SEQ_HI = 3'd4;
    localparam logic [2:0] STEP_SEQ_LO = 3'd5;
    localparam logic [2:0] STEP_DATA   = 3'd6;
    localparam logic [2:0] STEP_CRC    = 3'd7;

    // one classified payload beat
    typedef struct packed {
        logic [7:0]  data;
        logic [15:0] seq;
        logic        first;
        logic        last;
    } t_entry;

    // crc-8, msb first, no reflection
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* src/crc8_packet_framer.sv */
// ----------------------------------------------------------------------------
// crc8_packet_framer
// frames a payload byte stream with sync header, sequence number and crc-8
// ----------------------------------------------------------------------------
// usage
//   input channel: one payload byte per beat (i_in_valid / o_in_ready);
//     i_sequence_number is only looked at on the first beat of a frame
//   output channel: one framed byte per beat (o_out_valid / i_out_ready);
//     o_last_of_run marks the final byte caused by an input beat,
//     o_frame_end marks the closing crc byte
//   frame: AA 55 A5 5A, seq hi, seq lo, payload bytes, crc-8 (poly 0x07)
//   path: an accepted beat goes through the queue and the entry register to the output register
//   throughput: one output byte per cycle unless the receiver stalls, set by
//     the single emit sequencer; mid-frame beats flow at one per cycle, a
//     frame's first beat also emits header and sequence, the last one the crc
//   a 4-deep queue parts the front from the emit sequencer, so input beats
//     keep being taken while the receiver stalls until the queue fills
//   reset: frame position back to start of frame, queue and output emptied
// ----------------------------------------------------------------------------
module crc8_packet_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_payload_byte,
    input  logic [15:0] i_sequence_number,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run,
    output logic        o_frame_end
);
    import cpf_pkg::*;

    // front to queue
    logic   push;
    logic   full;
    t_entry front_entry;

    // queue to back
    logic   q_valid;
    logic   pop;
    t_entry q_entry;

    // accept beats, count frame position, tag first and last
    cpf_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_payload_byte    (i_payload_byte),
        .i_sequence_number (i_sequence_number),
        .i_full            (full),
        .o_push            (push),
        .o_entry           (front_entry)
    );

    // decouples input acceptance from output stalls
    cpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    // emits header, sequence, payload and crc bytes into the output register
    cpf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry_valid (q_valid),
        .i_entry       (q_entry),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_frame_end   (o_frame_end)
    );

endmodule

/* src/cpf_front.sv */
// ----------------------------------------------------------------------------
// cpf_front
// accepts payload beats, tracks frame position and tags first and last beats
// ----------------------------------------------------------------------------
module cpf_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_payload_byte,
    input  logic [15:0]         i_sequence_number,
    input  logic                i_full,
    output logic                o_push,
    output cpf_pkg::t_entry     o_entry
);
    import cpf_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             is_last;

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;
    assign is_last    = (r_pos >= LAST_POS);

    assign o_entry.data  = i_payload_byte;
    assign o_entry.seq   = i_sequence_number;
    assign o_entry.first = (r_pos == '0);
    assign o_entry.last  = is_last;

    always_comb begin
        n_pos = r_pos;
        if (o_push) begin
            n_pos = is_last ? '0 : r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

/* src/cpf_queue.sv */
// ----------------------------------------------------------------------------
// cpf_queue
// small first-word-fall-through queue of classified beats
// ----------------------------------------------------------------------------
module cpf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cpf_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output cpf_pkg::t_entry o_entry
);
    import cpf_pkg::*;

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* src/cpf_back.sv */
// ----------------------------------------------------------------------------
// cpf_back
// emit sequencer: header, sequence, payload and crc bytes, when not stalled one per cycle
// ----------------------------------------------------------------------------
module cpf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_entry_valid,
    input  cpf_pkg::t_entry i_entry,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run,
    output logic            o_frame_end
);
    import cpf_pkg::*;

    t_entry     r_entry;
    logic       r_have;
    logic [2:0] r_step;
    logic [7:0] r_crc;
    logic       r_ov;
    logic [7:0] r_byte;
    logic       r_lor;
    logic       r_fend;

    logic       adv;
    logic       emit;
    logic       finishing;
    logic       load;
    logic [7:0] cur_byte;
    logic [7:0] crc_base;

    assign adv       = !r_ov || i_out_ready;
    assign emit      = r_have && adv;
    assign finishing = emit && ((r_step == STEP_DATA && !r_entry.last) ||
                                (r_step == STEP_CRC));
    assign load      = i_entry_valid && (!r_have || finishing);
    assign o_pop     = load;

    always_comb begin
        unique case (r_step)
            STEP_HDR0:   cur_byte = SYNC0;
            STEP_HDR1:   cur_byte = SYNC1;
            STEP_HDR2:   cur_byte = SYNC2;
            STEP_HDR3:   cur_byte = SYNC3;
            STEP_SEQ_HI: cur_byte = r_entry.seq[15:8];
            STEP_SEQ_LO: cur_byte = r_entry.seq[7:0];
            STEP_DATA:   cur_byte = r_entry.data;
            STEP_CRC:    cur_byte = r_crc;
            default:     cur_byte = r_entry.data;
        endcase
    end

    // crc restarts with the first sync byte of every frame
    assign crc_base = (r_step == STEP_HDR0) ? 8'h00 : r_crc;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_entry <= i_entry;
        end
        if (emit) begin
            r_byte <= cur_byte;
            r_lor  <= (r_step == STEP_CRC) || (r_step == STEP_DATA && !r_entry.last);
            r_fend <= (r_step == STEP_CRC);
            if (r_step != STEP_CRC) begin
                r_crc <= crc8_byte(crc_base, cur_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_step <= STEP_HDR0;
            r_ov   <= 1'b0;
        end else begin
            if (load) begin
                r_have <= 1'b1;
                r_step <= i_entry.first ? STEP_HDR0 : STEP_DATA;
            end else if (finishing) begin
                r_have <= 1'b0;
            end else if (emit) begin
                r_step <= r_step + 3'd1;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (adv) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_ov;
    assign o_out_byte    = r_byte;
    assign o_last_of_run = r_lor;
    assign o_frame_end   = r_fend;

endmodule
